// ===== rtl/nearest_neighbor_resize_convert_top_macros.svh =====
// Assertion macros for the nearest-neighbor resize front end.
// Included by the RTL modules that carry concurrent assertions.
`ifndef NEAREST_NEIGHBOR_RESIZE_CONVERT_TOP_MACROS_SVH
`define NEAREST_NEIGHBOR_RESIZE_CONVERT_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define NNRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NNRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/nnrc_pkg.sv =====
// Shared constants, codes and helper functions of the nearest-neighbor
// resize front end. No dependencies.
package nnrc_pkg;

  localparam int DIM_W    = 13;   // size registers
  localparam int STRIDE_W = 16;
  localparam int CFG_W    = 16;   // widest register
  localparam int IDX_W    = 3;
  localparam int CNT_W    = 12;   // raster counters
  localparam int OFF_W    = 28;
  localparam int PIX_W    = 8;
  localparam int FMT_W    = 2;
  localparam int BPP_W    = 2;
  localparam int QUO_W    = 14;   // quotient bits produced, two per step
  localparam int STEP_N   = QUO_W / 2;
  localparam int STEP_W   = 3;
  localparam int PROD_W   = DIM_W + STRIDE_W;
  localparam int SCALE_W  = 15;   // pixel count times bytes per pixel

  localparam int MAX_DIM_DEF   = 4096;
  localparam int COUNTER_REACH = 4096;
  localparam int DIM_RESET     = 256;

  // register indexes
  localparam logic [IDX_W-1:0] REG_SRC_W  = 3'd0;
  localparam logic [IDX_W-1:0] REG_SRC_H  = 3'd1;
  localparam logic [IDX_W-1:0] REG_TGT_W  = 3'd2;
  localparam logic [IDX_W-1:0] REG_TGT_H  = 3'd3;
  localparam logic [IDX_W-1:0] REG_STRIDE = 3'd4;
  localparam logic [IDX_W-1:0] REG_FORMAT = 3'd5;

  // pixel formats
  localparam logic [FMT_W-1:0] FMT_RGB    = 2'd0;
  localparam logic [FMT_W-1:0] FMT_BGR    = 2'd1;
  localparam logic [FMT_W-1:0] FMT_GRAY8  = 2'd2;
  localparam logic [FMT_W-1:0] FMT_GRAY16 = 2'd3;

  localparam logic FUNC_ADDR  = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  // Force a size register into [1, lim].
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned lim);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    if (32'(v) > lim) r = DIM_W'(lim);
    return r;
  endfunction

  function automatic logic [BPP_W-1:0] bytes_per_pixel(input logic [FMT_W-1:0] fmt);
    logic [BPP_W-1:0] r;
    case (fmt)
      FMT_GRAY8:  r = BPP_W'(1);
      FMT_GRAY16: r = BPP_W'(2);
      default:    r = BPP_W'(3);
    endcase
    return r;
  endfunction

  // v times 1, 2 or 3 with shifts and one add
  function automatic logic [SCALE_W-1:0] times_bpp(input logic [DIM_W-1:0] v,
                                                   input logic [BPP_W-1:0] bpp);
    logic [SCALE_W-1:0] ext;
    logic [SCALE_W-1:0] r;
    ext = SCALE_W'(v);
    case (bpp)
      2'd1:    r = ext;
      2'd2:    r = ext << 1;
      default: r = (ext << 1) + ext;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/nearest_neighbor_resize_convert_top.sv =====
// Nearest-neighbor resize front end: address generator and pixel converter.
// Depends on nnrc_pkg and nearest_neighbor_resize_convert_top_macros.svh.
//
// From acceptance to a ready result, an address beat (func 0) uses one shared
// 13x16 multiplier and one two-bit-per-cycle restoring divider to compute the
// source column, then the source row (a multiply, then the divide steps, for
// each), then S_OFF forms the byte offset. A convert beat (func 1) goes to
// S_DONE. The input is not ready while a beat is in work; a finished result
// sits in the output register, so the next beat is accepted while it waits.
// Size registers are clamped to [1, MAX_DIM], target sizes also to 4096.
`include "nearest_neighbor_resize_convert_top_macros.svh"

module nearest_neighbor_resize_convert_top #(
  parameter int MAX_DIM = nnrc_pkg::MAX_DIM_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [nnrc_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [nnrc_pkg::CFG_W-1:0]  cfg_wdata_i,
  // input beats
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        func_i,
  input  logic [nnrc_pkg::PIX_W-1:0]  raw_byte_zero_i,
  input  logic [nnrc_pkg::PIX_W-1:0]  raw_byte_one_i,
  input  logic [nnrc_pkg::PIX_W-1:0]  raw_byte_two_i,
  // result beats
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        result_kind_o,
  output logic [nnrc_pkg::OFF_W-1:0]  source_offset_o,
  output logic [nnrc_pkg::CNT_W-1:0]  dest_col_o,
  output logic [nnrc_pkg::CNT_W-1:0]  dest_row_o,
  output logic                        frame_end_o,
  output logic [nnrc_pkg::PIX_W-1:0]  red_o,
  output logic [nnrc_pkg::PIX_W-1:0]  green_o,
  output logic [nnrc_pkg::PIX_W-1:0]  blue_o
);

  localparam int TGT_MAX = (MAX_DIM < nnrc_pkg::COUNTER_REACH) ? MAX_DIM
                                                               : nnrc_pkg::COUNTER_REACH;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_OFF  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam int DW = nnrc_pkg::DIM_W;
  localparam int CW = nnrc_pkg::CNT_W;
  localparam int PW = nnrc_pkg::PIX_W;
  localparam int OW = nnrc_pkg::OFF_W;
  localparam int QW = nnrc_pkg::QUO_W;
  localparam int RW = CW;  // remainder stays below a target size <= 4096

  // configuration registers
  logic [DW-1:0]                    src_w_q, src_h_q, tgt_w_q, tgt_h_q;
  logic [nnrc_pkg::STRIDE_W-1:0]    stride_q;
  logic [nnrc_pkg::FMT_W-1:0]       fmt_q;

  // raster counters
  logic [CW-1:0] col_q, col_d, row_q, row_d;

  // sequencer
  logic [2:0]                       state_q, state_d;
  logic                             axis_q, axis_d;
  logic [nnrc_pkg::STEP_W-1:0]      step_q, step_d;

  // divider datapath
  logic [RW-1:0] rem_q, rem_d;
  logic [QW-1:0] lo_q, lo_d, quo_q, quo_d;
  logic [DW-1:0] div_q, div_d, lim_q, lim_d;
  logic          clamp_q, clamp_d;

  // pending result
  logic          kind_q, kind_d;
  logic [CW-1:0] x_q, x_d, y_q, y_d;
  logic [DW-1:0] sx_q, sx_d, sy_q, sy_d;
  logic          fend_q, fend_d;
  logic [OW-1:0] off_q, off_d;
  logic [PW-1:0] r_q, r_d, g_q, g_d, b_q, b_d;

  // output register
  logic          out_valid_q, out_valid_d;
  logic          o_kind_q;
  logic [OW-1:0] o_off_q;
  logic [CW-1:0] o_col_q, o_row_q;
  logic          o_fend_q;
  logic [PW-1:0] o_r_q, o_g_q, o_b_q;
  logic          out_load;

  // effective sizes and geometry
  logic [DW-1:0]                  sw, sh, tw, th;
  logic [nnrc_pkg::BPP_W-1:0]     bpp;
  logic [nnrc_pkg::STRIDE_W-1:0]  stride;
  logic                           in_acc;
  logic                           row_done, last_row;

  // shared multiplier
  logic [DW-1:0]                  mul_a;
  logic [nnrc_pkg::STRIDE_W-1:0]  mul_b;
  logic [nnrc_pkg::PROD_W-1:0]    prod;

  // divide step
  logic [RW:0]   r1, r2;
  logic          ge1, ge2;
  logic [DW-1:0] quo_fin;

  assign sw  = nnrc_pkg::clamp_dim(src_w_q, MAX_DIM);
  assign sh  = nnrc_pkg::clamp_dim(src_h_q, MAX_DIM);
  assign tw  = nnrc_pkg::clamp_dim(tgt_w_q, TGT_MAX);
  assign th  = nnrc_pkg::clamp_dim(tgt_h_q, TGT_MAX);
  assign bpp = nnrc_pkg::bytes_per_pixel(fmt_q);
  assign stride = (stride_q != '0) ? stride_q
                : nnrc_pkg::STRIDE_W'(nnrc_pkg::times_bpp(sw, bpp));

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign row_done   = {1'b0, col_q} >= (tw - DW'(1));
  assign last_row   = {1'b0, row_q} >= (th - DW'(1));

  always_comb begin
    unique case (state_q)
      S_MUL: begin
        mul_a = axis_q ? DW'(y_q) : DW'(x_q);
        mul_b = nnrc_pkg::STRIDE_W'(axis_q ? sh : sw);
      end
      default: begin
        mul_a = sy_q;
        mul_b = stride;
      end
    endcase
  end
  assign prod = nnrc_pkg::PROD_W'(mul_a) * nnrc_pkg::PROD_W'(mul_b);

  // two restoring steps per cycle
  always_comb begin
    r1  = {rem_q, lo_q[QW-1]};
    ge1 = r1 >= (RW+1)'(div_q);
    if (ge1) r1 = r1 - (RW+1)'(div_q);
    r2  = {r1[RW-1:0], lo_q[QW-2]};
    ge2 = r2 >= (RW+1)'(div_q);
    if (ge2) r2 = r2 - (RW+1)'(div_q);
  end
  assign quo_fin = DW'({quo_q[QW-3:0], ge1, ge2});

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    step_d  = step_q;
    rem_d   = rem_q;
    lo_d    = lo_q;
    quo_d   = quo_q;
    div_d   = div_q;
    lim_d   = lim_q;
    clamp_d = clamp_q;
    kind_d  = kind_q;
    x_d     = x_q;
    y_d     = y_q;
    sx_d    = sx_q;
    sy_d    = sy_q;
    fend_d  = fend_q;
    off_d   = off_q;
    r_d     = r_q;
    g_d     = g_q;
    b_d     = b_q;
    col_d   = col_q;
    row_d   = row_q;
    out_load = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          kind_d = func_i;
          if (func_i == nnrc_pkg::FUNC_PIXEL) begin
            off_d  = '0;
            x_d    = '0;
            y_d    = '0;
            fend_d = 1'b0;
            case (fmt_q)
              nnrc_pkg::FMT_RGB: begin
                r_d = raw_byte_zero_i; g_d = raw_byte_one_i; b_d = raw_byte_two_i;
              end
              nnrc_pkg::FMT_BGR: begin
                r_d = raw_byte_two_i; g_d = raw_byte_one_i; b_d = raw_byte_zero_i;
              end
              nnrc_pkg::FMT_GRAY8: begin
                r_d = raw_byte_zero_i; g_d = raw_byte_zero_i; b_d = raw_byte_zero_i;
              end
              default: begin
                r_d = raw_byte_one_i; g_d = raw_byte_one_i; b_d = raw_byte_one_i;
              end
            endcase
            state_d = S_DONE;
          end else begin
            r_d    = '0;
            g_d    = '0;
            b_d    = '0;
            x_d    = col_q;
            y_d    = row_q;
            fend_d = row_done && last_row;
            // advance raster; user must hold sizes till beat done (unenforced)
            if (row_done) begin
              col_d = '0;
              row_d = last_row ? '0 : row_q + CW'(1);
            end else begin
              col_d = col_q + CW'(1);
            end
            axis_d  = 1'b0;
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        // quotient is known to fit 13 bits unless pos >= dst, which clamps
        rem_d   = RW'(prod[nnrc_pkg::PROD_W-1:QW]);
        lo_d    = prod[QW-1:0];
        quo_d   = '0;
        div_d   = axis_q ? th : tw;
        lim_d   = (axis_q ? sh : sw) - DW'(1);
        clamp_d = axis_q ? ({1'b0, y_q} >= th) : ({1'b0, x_q} >= tw);
        step_d  = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        rem_d  = r2[RW-1:0];
        lo_d   = lo_q << 2;
        quo_d  = {quo_q[QW-3:0], ge1, ge2};
        step_d = step_q + nnrc_pkg::STEP_W'(1);
        if (step_q == nnrc_pkg::STEP_W'(nnrc_pkg::STEP_N - 1)) begin
          if (axis_q) begin
            sy_d    = clamp_q ? lim_q : quo_fin;
            state_d = S_OFF;
          end else begin
            sx_d    = clamp_q ? lim_q : quo_fin;
            axis_d  = 1'b1;
            state_d = S_MUL;
          end
        end
      end
      S_OFF: begin
        off_d   = OW'(prod + nnrc_pkg::PROD_W'(nnrc_pkg::times_bpp(sx_q, bpp)));
        state_d = S_DONE;
      end
      S_DONE: begin
        // hold until the output register frees up
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q     <= DW'(nnrc_pkg::DIM_RESET);
      src_h_q     <= DW'(nnrc_pkg::DIM_RESET);
      tgt_w_q     <= DW'(nnrc_pkg::DIM_RESET);
      tgt_h_q     <= DW'(nnrc_pkg::DIM_RESET);
      stride_q    <= '0;
      fmt_q       <= nnrc_pkg::FMT_RGB;
      col_q       <= '0;
      row_q       <= '0;
      state_q     <= S_IDLE;
      axis_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          nnrc_pkg::REG_SRC_W:  src_w_q  <= cfg_wdata_i[DW-1:0];
          nnrc_pkg::REG_SRC_H:  src_h_q  <= cfg_wdata_i[DW-1:0];
          nnrc_pkg::REG_TGT_W:  tgt_w_q  <= cfg_wdata_i[DW-1:0];
          nnrc_pkg::REG_TGT_H:  tgt_h_q  <= cfg_wdata_i[DW-1:0];
          nnrc_pkg::REG_STRIDE: stride_q <= cfg_wdata_i[nnrc_pkg::STRIDE_W-1:0];
          nnrc_pkg::REG_FORMAT: fmt_q    <= cfg_wdata_i[nnrc_pkg::FMT_W-1:0];
          default: ;
        endcase
      end
      col_q       <= col_d;
      row_q       <= row_d;
      state_q     <= state_d;
      axis_q      <= axis_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    lo_q    <= lo_d;
    quo_q   <= quo_d;
    div_q   <= div_d;
    lim_q   <= lim_d;
    clamp_q <= clamp_d;
    kind_q  <= kind_d;
    x_q     <= x_d;
    y_q     <= y_d;
    sx_q    <= sx_d;
    sy_q    <= sy_d;
    fend_q  <= fend_d;
    off_q   <= off_d;
    r_q     <= r_d;
    g_q     <= g_d;
    b_q     <= b_d;
    if (out_load) begin
      o_kind_q <= kind_q;
      o_off_q  <= off_q;
      o_col_q  <= x_q;
      o_row_q  <= y_q;
      o_fend_q <= fend_q;
      o_r_q    <= r_q;
      o_g_q    <= g_q;
      o_b_q    <= b_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = o_kind_q;
  assign source_offset_o = o_off_q;
  assign dest_col_o      = o_col_q;
  assign dest_row_o      = o_row_q;
  assign frame_end_o     = o_fend_q;
  assign red_o           = o_r_q;
  assign green_o         = o_g_q;
  assign blue_o          = o_b_q;

  // a clamped coordinate runs the divider on a dividend it ignores
  `NNRC_ASSERT_NOW(a_rem_below_div, state_q == S_DIV && !clamp_q, {1'b0, rem_q} < div_q, "remainder not below divisor")
  `NNRC_ASSERT_NOW(a_step_range, state_q == S_DIV, step_q < nnrc_pkg::STEP_W'(nnrc_pkg::STEP_N), "divide step count out of range")
  `NNRC_ASSERT_NEXT(a_row_wrap, in_acc && func_i == nnrc_pkg::FUNC_ADDR && row_done, col_q == '0, "column did not wrap at end of row")
  `NNRC_ASSERT_NEXT(a_pixel_keeps_raster, in_acc && func_i == nnrc_pkg::FUNC_PIXEL, $stable(col_q) && $stable(row_q), "convert beat moved the raster")
  `NNRC_ASSERT_NEXT(a_load_sets_valid, out_load, out_valid_q && state_q == S_IDLE, "result load did not show a valid beat")

endmodule
